/* sv/bci_pkg.sv */
package bci_pkg;

  localparam int unsigned NumPoints = 8;
  localparam int unsigned NumKinds  = 4;

  localparam int unsigned MvW      = 12;
  localparam int unsigned ChW      = 8;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ProdW    = MvW + ChW;
  localparam int unsigned RowSelW  = (NumKinds > 1) ? $clog2(NumKinds) : 1;

  // Edges from the accepting edge to the edge that takes the result: ROM read,
  // segment select, multiply, one divider stage per quotient bit, final stage.
  localparam int unsigned PipeLatency = ChW + 4;

  typedef logic [MvW-1:0]   mv_t;
  typedef logic [ChW-1:0]   charge_t;
  typedef logic [KindW-1:0] kind_t;
  typedef logic [ProdW-1:0] prod_t;

  typedef mv_t     mv_row_t     [NumPoints];
  typedef charge_t charge_row_t [NumPoints];

  // Breakpoint voltages in millivolts, one row for each battery type.
  localparam mv_row_t BpMv [NumKinds] = '{
    '{12'd2800, 12'd3000, 12'd3100, 12'd3150, 12'd3250, 12'd3300, 12'd3400, 12'd3600},
    '{12'd2800, 12'd3000, 12'd3100, 12'd3150, 12'd3250, 12'd3300, 12'd3400, 12'd3600},
    '{12'd2800, 12'd3000, 12'd3100, 12'd3150, 12'd3250, 12'd3300, 12'd3400, 12'd3600},
    '{12'd2800, 12'd3000, 12'd3100, 12'd3150, 12'd3250, 12'd3300, 12'd3400, 12'd3600}
  };

  // Charge levels at the breakpoints above.
  localparam charge_row_t BpCharge [NumKinds] = '{
    '{8'd0, 8'd25, 8'd50, 8'd96,  8'd160, 8'd200, 8'd225, 8'd255},
    '{8'd0, 8'd25, 8'd50, 8'd100, 8'd150, 8'd200, 8'd225, 8'd255},
    '{8'd0, 8'd25, 8'd50, 8'd100, 8'd150, 8'd200, 8'd225, 8'd255},
    '{8'd0, 8'd25, 8'd50, 8'd100, 8'd150, 8'd200, 8'd225, 8'd255}
  };

endpackage

/* sv/battery_charge_interpolator_unit.sv */
// Battery charge interpolator.
// A voltage beat is accepted on a rising edge with start_i high and busy_o low.
// busy_o stays low: the block takes one voltage every clock cycle.
// The charge level appears on charge_level_o with valid_o high for exactly one
// cycle, from the register of the final stage; results leave in the order the
// voltages came in. Throughput is one beat per cycle.
// The path is a fixed pipeline: a registered read of the breakpoint row ROM,
// segment select, one 8x12 multiply, eight restoring divider stages of one
// quotient bit each, and a final rounding and saturation stage. The receiver
// cannot stall, so nothing is ever held back.
// cfg_we_i writes cfg_wdata_i into the battery type register on the same edge;
// change it only while no beat is in flight. A type beyond the table uses row 0.
// Reset clears the type register to 0 and drops every beat in flight; no
// clearing pass is needed since the ROM holds constants.
module battery_charge_interpolator_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  bci_pkg::mv_t         voltage_mv_i,
  input  logic                 cfg_we_i,
  input  bci_pkg::kind_t       cfg_wdata_i,
  output logic                 valid_o,
  output bci_pkg::charge_t     charge_level_o
);

  localparam int unsigned Stages = bci_pkg::ChW;

  logic accept;
  bci_pkg::kind_t battery_kind_q;
  logic [bci_pkg::RowSelW-1:0] row_sel;

  // Stage 1: ROM read.
  logic                  vld_s1_q;
  bci_pkg::mv_t          v_s1_q;
  bci_pkg::mv_row_t      row_mv_q;
  bci_pkg::charge_row_t  row_ch_q;

  // Stage 1 to 2 logic.
  logic                  hit;
  bci_pkg::mv_t          vlo, vhi;
  bci_pkg::charge_t      clo, chi;
  logic                  force_d, neg_d;
  bci_pkg::charge_t      base_d, mag_d;
  bci_pkg::mv_t          dv_d, den_d;

  // Stage 2: segment chosen.
  logic                  vld_s2_q;
  logic                  force_s2_q, neg_s2_q;
  bci_pkg::charge_t      base_s2_q, mag_s2_q;
  bci_pkg::mv_t          dv_s2_q, den_s2_q;

  // Divider stages; entry 0 holds the product.
  logic [Stages:0]       vld_st_q, neg_st_q, force_st_q;
  bci_pkg::prod_t        rem_st_q  [Stages+1];
  bci_pkg::charge_t      quo_st_q  [Stages+1];
  bci_pkg::mv_t          den_st_q  [Stages+1];
  bci_pkg::charge_t      base_st_q [Stages+1];
  bci_pkg::prod_t        rem_st_d  [Stages];
  bci_pkg::charge_t      quo_st_d  [Stages];

  // Final stage.
  logic signed [bci_pkg::ChW+1:0] sum;
  bci_pkg::charge_t      result_d;
  logic                  valid_q;
  bci_pkg::charge_t      charge_level_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      battery_kind_q <= '0;
    end else if (cfg_we_i) begin
      battery_kind_q <= cfg_wdata_i;
    end
  end

  assign row_sel = (32'(battery_kind_q) < bci_pkg::NumKinds) ?
                   bci_pkg::RowSelW'(battery_kind_q) : '0;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_mv_q <= bci_pkg::BpMv[row_sel];
      row_ch_q <= bci_pkg::BpCharge[row_sel];
      v_s1_q   <= voltage_mv_i;
    end
  end

  // The lowest segment that holds the voltage wins, so scan from the top.
  always_comb begin
    hit = 1'b0;
    vlo = row_mv_q[0];
    vhi = row_mv_q[0];
    clo = row_ch_q[0];
    chi = row_ch_q[0];
    for (int i = bci_pkg::NumPoints - 2; i >= 0; i--) begin
      if (v_s1_q >= row_mv_q[i] && v_s1_q <= row_mv_q[i+1]) begin
        hit = 1'b1;
        vlo = row_mv_q[i];
        vhi = row_mv_q[i+1];
        clo = row_ch_q[i];
        chi = row_ch_q[i+1];
      end
    end
    dv_d  = v_s1_q - vlo;
    den_d = vhi - vlo;
    neg_d = chi < clo;
    mag_d = neg_d ? (clo - chi) : (chi - clo);
    force_d = 1'b1;
    base_d  = clo;
    if (v_s1_q <= row_mv_q[0]) begin
      base_d = '0;
    end else if (v_s1_q >= row_mv_q[bci_pkg::NumPoints-1]) begin
      base_d = '1;
    end else if (!hit) begin
      base_d = '0;
    end else if (vhi > vlo) begin
      force_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    force_s2_q <= force_d;
    neg_s2_q   <= neg_d;
    base_s2_q  <= base_d;
    mag_s2_q   <= mag_d;
    dv_s2_q    <= dv_d;
    den_s2_q   <= den_d;
  end

  // The voltage never leaves its segment, so the quotient fits in eight bits.
  always_comb begin
    for (int s = 0; s < Stages; s++) begin
      bci_pkg::prod_t sh;
      sh = bci_pkg::prod_t'(den_st_q[s]) << (Stages - 1 - s);
      if (rem_st_q[s] >= sh) begin
        rem_st_d[s] = rem_st_q[s] - sh;
        quo_st_d[s] = {quo_st_q[s][bci_pkg::ChW-2:0], 1'b1};
      end else begin
        rem_st_d[s] = rem_st_q[s];
        quo_st_d[s] = {quo_st_q[s][bci_pkg::ChW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_st_q[0]   <= bci_pkg::prod_t'(mag_s2_q) * bci_pkg::prod_t'(dv_s2_q);
    quo_st_q[0]   <= '0;
    den_st_q[0]   <= den_s2_q;
    base_st_q[0]  <= base_s2_q;
    neg_st_q[0]   <= neg_s2_q;
    force_st_q[0] <= force_s2_q;
    for (int s = 0; s < Stages; s++) begin
      rem_st_q[s+1]   <= rem_st_d[s];
      quo_st_q[s+1]   <= quo_st_d[s];
      den_st_q[s+1]   <= den_st_q[s];
      base_st_q[s+1]  <= base_st_q[s];
      neg_st_q[s+1]   <= neg_st_q[s];
      force_st_q[s+1] <= force_st_q[s];
    end
  end

  // A negative slope rounds toward minus infinity: one more when a remainder is left.
  always_comb begin
    if (neg_st_q[Stages]) begin
      sum = $signed({2'b00, base_st_q[Stages]}) - $signed({2'b00, quo_st_q[Stages]})
            - $signed({{(bci_pkg::ChW+1){1'b0}}, (rem_st_q[Stages] != '0)});
    end else begin
      sum = $signed({2'b00, base_st_q[Stages]}) + $signed({2'b00, quo_st_q[Stages]});
    end
    if (force_st_q[Stages]) begin
      result_d = base_st_q[Stages];
    end else if (sum < 0) begin
      result_d = '0;
    end else if (sum > $signed({2'b00, {bci_pkg::ChW{1'b1}}})) begin
      result_d = '1;
    end else begin
      result_d = sum[bci_pkg::ChW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    charge_level_q <= result_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_s1_q <= 1'b0;
      vld_s2_q <= 1'b0;
      vld_st_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      vld_s1_q <= accept;
      vld_s2_q <= vld_s1_q;
      vld_st_q <= {vld_st_q[Stages-1:0], vld_s2_q};
      valid_q  <= vld_st_q[Stages];
    end
  end

  assign valid_o        = valid_q;
  assign charge_level_o = charge_level_q;

endmodule

/* sv/bci_checker.sv */
module bci_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start_i,
  input logic             busy_o,
  input bci_pkg::mv_t     voltage_mv_i,
  input logic             valid_o,
  input bci_pkg::charge_t charge_level_o
);

  localparam int unsigned Latency = bci_pkg::PipeLatency;

  // Every accepted beat produces its result once it has passed the whole pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##Latency valid_o)
    else $error("accepted beat produced no result");

  // No result appears without an accepted beat that has passed the whole pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i && !busy_o, Latency))
    else $error("result without an accepted beat");

  // A dead battery reads empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && voltage_mv_i == '0) |-> ##Latency (charge_level_o == '0))
    else $error("zero voltage did not read empty");

  // Full scale input reads full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && voltage_mv_i == '1) |-> ##Latency (charge_level_o == '1))
    else $error("full scale voltage did not read full");

endmodule

bind battery_charge_interpolator_unit bci_checker u_bci_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .voltage_mv_i   (voltage_mv_i),
  .valid_o        (valid_o),
  .charge_level_o (charge_level_o)
);
